// ----- hdl/swsm_pkg.sv -----
// ----------------------------------------------------------------------------
// swsm_pkg
// Shared sizes, types and constant tables of the sliding window slot map.
// ----------------------------------------------------------------------------
package swsm_pkg;

  localparam int WINDOW  = 4;
  localparam int CELLS   = WINDOW * WINDOW;
  localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int IDX_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ENT_W   = $clog2(WINDOW + 1);
  localparam int DIST_W  = (WINDOW > 1) ? $clog2(2 * WINDOW - 1) : 1;
  localparam int COORD_W = 16;
  localparam int SLOT_W  = 3;
  localparam int OFF_W   = COORD_W + 2;
  localparam int AREA_W  = 2 * ENT_W;

  localparam logic [ENT_W-1:0] EMPTY = ENT_W'(WINDOW);

  function automatic int isqrt_c(int n);
    int h;
    h = 1;
    while ((h + 1) * (h + 1) <= n) h++;
    return h;
  endfunction

  localparam int INIT_H = isqrt_c(WINDOW);
  localparam int INIT_D = WINDOW / INIT_H;

  typedef logic [CELLS-1:0][ENT_W-1:0] init_tab_t;

  function automatic init_tab_t init_tab_c();
    init_tab_t t;
    for (int k = 0; k < CELLS; k++) t[k] = EMPTY;
    for (int j = 0; j < INIT_H; j++) begin
      for (int i = 0; i < INIT_D; i++) begin
        t[j * WINDOW + i] = ENT_W'(j * INIT_D + i);
      end
    end
    return t;
  endfunction

  localparam init_tab_t INIT_TAB = init_tab_c();

  function automatic logic [IDX_W-1:0] cell_idx(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
    return IDX_W'(IDX_W'(y) * IDX_W'(WINDOW) + IDX_W'(x));
  endfunction

  function automatic logic [ENT_W-1:0] overlap_1d(logic [COORD_W-1:0] a,
                                                  logic [COORD_W-1:0] b);
    logic [COORD_W:0] lo;
    logic [COORD_W:0] hi;
    lo = (a > b) ? {1'b0, a} : {1'b0, b};
    hi = ((a < b) ? {1'b0, a} : {1'b0, b}) + (COORD_W + 1)'(WINDOW - 1);
    return (hi >= lo) ? ENT_W'(hi - lo + 1'b1) : '0;
  endfunction

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] idx;
  } tbl_rd_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] idx;
    logic [ENT_W-1:0] val;
  } tbl_wr_t;

  typedef struct packed {
    logic             free_ok;
    logic [ENT_W-1:0] free_slot;
    logic             far_ok;
    logic [POS_W-1:0] far_x;
    logic [POS_W-1:0] far_y;
    logic [ENT_W-1:0] far_slot;
    logic [ENT_W-1:0] tgt_slot;
  } scan_res_t;

endpackage

// ----- hdl/sliding_window_slot_map.sv -----
// ----------------------------------------------------------------------------
// sliding_window_slot_map
// Maps block coordinates of a sliding window to physical slots; looks up
// blocks and places loaded blocks, moving the window when needed.
//
//   channel  signals                                   direction
//   in       in_valid_i/in_ready_o, kind, block_x/y    into the block
//   out      out_valid_o/out_ready_i, slot, loaded,    out of the block
//            origin_x/y
//
// One item at a time. A lookup outside the window answers empty with no table
// read; one inside reads its entry. A load sweeps the table; outside the window
// it first moves the window, copying kept entries to the fresh bank. A sweep
// reads all CELLS (16) entries on the single read port, one entry per cycle.
// Reset needs no clearing pass: per-entry flags restore the start pattern.
// A result waits in the output register; the next item is taken meanwhile,
// and its result holds until the output register drains.
// ----------------------------------------------------------------------------
module sliding_window_slot_map import swsm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [COORD_W-1:0] block_x_i,
  input  logic [COORD_W-1:0] block_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SLOT_W-1:0]  slot_o,
  output logic               loaded_o,
  output logic [COORD_W-1:0] origin_x_o,
  output logic [COORD_W-1:0] origin_y_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LK_RD    = 4'd1;
  localparam logic [3:0] S_LK_DATA  = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_SCAN_END = 4'd4;
  localparam logic [3:0] S_DECIDE   = 4'd5;
  localparam logic [3:0] S_STEAL    = 4'd6;
  localparam logic [3:0] S_CAND     = 4'd7;
  localparam logic [3:0] S_ORIGIN   = 4'd8;
  localparam logic [3:0] S_MOVE     = 4'd9;
  localparam logic [3:0] S_MOVE_END = 4'd10;
  localparam logic [3:0] S_PLACE    = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW - 1);

  logic [3:0]                state_q, state_d;
  logic [COORD_W-1:0]        bx_q, bx_d, by_q, by_d;
  logic [POS_W-1:0]          tx_q, tx_d, ty_q, ty_d;
  logic [COORD_W-1:0]        wl_q, wl_d, wt_q, wt_d;
  logic [COORD_W-1:0]        nl_q, nl_d, nt_q, nt_d;
  logic [AREA_W-1:0]         best_area_q, best_area_d;
  logic [1:0]                cand_q, cand_d;
  logic signed [OFF_W-1:0]   offx_q, offx_d, offy_q, offy_d;
  logic                      bank_q, bank_d;
  logic [POS_W-1:0]          ci_q, ci_d, cj_q, cj_d;
  logic                      rd_live_q, rd_live_d;
  logic [POS_W-1:0]          rd_i_q, rd_i_d, rd_j_q, rd_j_d;
  logic [ENT_W-1:0]          freed_q, freed_d;
  logic [ENT_W-1:0]          res_q, res_d;
  logic                      out_valid_q, out_valid_d;
  logic [SLOT_W-1:0]         slot_q, slot_d;
  logic                      loaded_q, loaded_d;
  logic [COORD_W-1:0]        ox_q, ox_d, oy_q, oy_d;

  tbl_rd_t                   rd;
  tbl_wr_t                   wr;
  logic                      tbl_clr;
  logic [ENT_W-1:0]          rd_data;
  logic                      scan_clr;
  logic                      scan_take;
  scan_res_t                 sres;

  logic                      accept;
  logic                      inwin;
  logic [COORD_W-1:0]        sx, sy, cx, cy;
  logic [AREA_W-1:0]         area;
  logic signed [OFF_W-1:0]   ni, nj;
  logic                      keep;

  swsm_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_i       (rd),
    .rd_data_o  (rd_data),
    .wr_i       (wr),
    .clr_i      (tbl_clr),
    .clr_bank_i (~bank_q)
  );

  swsm_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (scan_clr),
    .take_i  (scan_take),
    .pos_x_i (rd_i_q),
    .pos_y_i (rd_j_q),
    .val_i   (rd_data),
    .tgt_x_i (tx_q),
    .tgt_y_i (ty_q),
    .res_o   (sres)
  );

  assign accept = in_valid_i && in_ready_o;
  assign inwin  = (block_x_i >= wl_q) &&
                  ({1'b0, block_x_i} < {1'b0, wl_q} + (COORD_W + 1)'(WINDOW)) &&
                  (block_y_i >= wt_q) &&
                  ({1'b0, block_y_i} < {1'b0, wt_q} + (COORD_W + 1)'(WINDOW));

  assign sx   = (bx_q >= COORD_W'(WINDOW - 1)) ? bx_q - COORD_W'(WINDOW - 1) : '0;
  assign sy   = (by_q >= COORD_W'(WINDOW - 1)) ? by_q - COORD_W'(WINDOW - 1) : '0;
  assign cx   = cand_q[0] ? bx_q : sx;
  assign cy   = cand_q[1] ? by_q : sy;
  assign area = AREA_W'(overlap_1d(wl_q, cx)) * AREA_W'(overlap_1d(wt_q, cy));

  assign ni   = $signed({{(OFF_W - POS_W){1'b0}}, rd_i_q}) + offx_q;
  assign nj   = $signed({{(OFF_W - POS_W){1'b0}}, rd_j_q}) + offy_q;
  assign keep = !ni[OFF_W-1] && (ni < $signed(OFF_W'(WINDOW))) &&
                !nj[OFF_W-1] && (nj < $signed(OFF_W'(WINDOW)));

  assign scan_take  = rd_live_q && (state_q == S_SCAN || state_q == S_SCAN_END);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    bx_d        = bx_q;
    by_d        = by_q;
    tx_d        = tx_q;
    ty_d        = ty_q;
    wl_d        = wl_q;
    wt_d        = wt_q;
    nl_d        = nl_q;
    nt_d        = nt_q;
    best_area_d = best_area_q;
    cand_d      = cand_q;
    offx_d      = offx_q;
    offy_d      = offy_q;
    bank_d      = bank_q;
    ci_d        = ci_q;
    cj_d        = cj_q;
    rd_live_d   = 1'b0;
    rd_i_d      = rd_i_q;
    rd_j_d      = rd_j_q;
    freed_d     = freed_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    slot_d      = slot_q;
    loaded_d    = loaded_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    rd          = '0;
    wr          = '0;
    tbl_clr     = 1'b0;
    scan_clr    = 1'b0;

    // advance the sweep over the active bank
    if (state_q == S_SCAN || state_q == S_MOVE) begin
      rd.en     = 1'b1;
      rd.bank   = bank_q;
      rd.idx    = cell_idx(ci_q, cj_q);
      rd_live_d = 1'b1;
      rd_i_d    = ci_q;
      rd_j_d    = cj_q;
      if (ci_q == LAST_POS) begin
        ci_d = '0;
        cj_d = cj_q + 1'b1;
      end else begin
        ci_d = ci_q + 1'b1;
      end
    end

    // copy kept entries into the fresh bank, remember the last one dropped
    if (rd_live_q && (state_q == S_MOVE || state_q == S_MOVE_END)) begin
      if (keep) begin
        wr.en   = 1'b1;
        wr.bank = ~bank_q;
        wr.idx  = cell_idx(POS_W'(ni), POS_W'(nj));
        wr.val  = rd_data;
      end else if (rd_data != EMPTY) begin
        freed_d = rd_data;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          bx_d = block_x_i;
          by_d = block_y_i;
          tx_d = POS_W'(block_x_i - wl_q);
          ty_d = POS_W'(block_y_i - wt_q);
          ci_d = '0;
          cj_d = '0;
          if (!inwin) begin
            if (kind_i) begin
              cand_d  = '0;
              state_d = S_CAND;
            end else begin
              res_d   = EMPTY;
              state_d = S_DONE;
            end
          end else if (kind_i) begin
            scan_clr = 1'b1;
            state_d  = S_SCAN;
          end else begin
            state_d = S_LK_RD;
          end
        end
      end
      S_LK_RD: begin
        rd.en   = 1'b1;
        rd.bank = bank_q;
        rd.idx  = cell_idx(tx_q, ty_q);
        state_d = S_LK_DATA;
      end
      S_LK_DATA: begin
        res_d   = rd_data;
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (ci_q == LAST_POS && cj_q == LAST_POS) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        wr.bank = bank_q;
        wr.idx  = cell_idx(tx_q, ty_q);
        if (sres.free_ok) begin
          wr.en   = 1'b1;
          wr.val  = sres.free_slot;
          res_d   = sres.free_slot;
          state_d = S_DONE;
        end else if (sres.far_ok) begin
          wr.en   = 1'b1;
          wr.val  = sres.far_slot;
          res_d   = sres.far_slot;
          state_d = S_STEAL;
        end else begin
          res_d   = sres.tgt_slot;
          state_d = S_DONE;
        end
      end
      S_STEAL: begin
        wr.en   = 1'b1;
        wr.bank = bank_q;
        wr.idx  = cell_idx(sres.far_x, sres.far_y);
        wr.val  = EMPTY;
        state_d = S_DONE;
      end
      S_CAND: begin
        if (cand_q == 2'd0 || area > best_area_q) begin
          best_area_d = area;
          nl_d        = cx;
          nt_d        = cy;
        end
        cand_d = cand_q + 1'b1;
        if (cand_q == 2'd3) begin
          state_d = S_ORIGIN;
        end
      end
      S_ORIGIN: begin
        offx_d  = $signed({2'b00, wl_q}) - $signed({2'b00, nl_q});
        offy_d  = $signed({2'b00, wt_q}) - $signed({2'b00, nt_q});
        wl_d    = nl_q;
        wt_d    = nt_q;
        tx_d    = POS_W'(bx_q - nl_q);
        ty_d    = POS_W'(by_q - nt_q);
        freed_d = EMPTY;
        tbl_clr = 1'b1;
        ci_d    = '0;
        cj_d    = '0;
        state_d = S_MOVE;
      end
      S_MOVE: begin
        if (ci_q == LAST_POS && cj_q == LAST_POS) begin
          state_d = S_MOVE_END;
        end
      end
      S_MOVE_END: begin
        bank_d  = ~bank_q;
        state_d = S_PLACE;
      end
      S_PLACE: begin
        if (freed_q != EMPTY) begin
          wr.en   = 1'b1;
          wr.bank = bank_q;
          wr.idx  = cell_idx(tx_q, ty_q);
          wr.val  = freed_q;
          res_d   = freed_q;
          state_d = S_DONE;
        end else begin
          scan_clr = 1'b1;
          ci_d     = '0;
          cj_d     = '0;
          state_d  = S_SCAN;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          slot_d      = SLOT_W'(res_q);
          loaded_d    = (res_q != EMPTY);
          ox_d        = wl_q;
          oy_d        = wt_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wl_q        <= '0;
      wt_q        <= '0;
      bank_q      <= 1'b0;
      rd_live_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cand_q      <= '0;
      ci_q        <= '0;
      cj_q        <= '0;
    end else begin
      state_q     <= state_d;
      wl_q        <= wl_d;
      wt_q        <= wt_d;
      bank_q      <= bank_d;
      rd_live_q   <= rd_live_d;
      out_valid_q <= out_valid_d;
      cand_q      <= cand_d;
      ci_q        <= ci_d;
      cj_q        <= cj_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bx_q        <= bx_d;
    by_q        <= by_d;
    tx_q        <= tx_d;
    ty_q        <= ty_d;
    nl_q        <= nl_d;
    nt_q        <= nt_d;
    best_area_q <= best_area_d;
    offx_q      <= offx_d;
    offy_q      <= offy_d;
    rd_i_q      <= rd_i_d;
    rd_j_q      <= rd_j_d;
    freed_q     <= freed_d;
    res_q       <= res_d;
    slot_q      <= slot_d;
    loaded_q    <= loaded_d;
    ox_q        <= ox_d;
    oy_q        <= oy_d;
  end

  assign out_valid_o = out_valid_q;
  assign slot_o      = slot_q;
  assign loaded_o    = loaded_q;
  assign origin_x_o  = ox_q;
  assign origin_y_o  = oy_q;

endmodule

// ----- hdl/swsm_table.sv -----
// ----------------------------------------------------------------------------
// swsm_table
// Two-bank slot table memory, one read and one write port, registered read.
// Per-entry written flags let a bank read as its reset pattern or as empty.
// ----------------------------------------------------------------------------
module swsm_table import swsm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbl_rd_t          rd_i,
  output logic [ENT_W-1:0] rd_data_o,
  input  tbl_wr_t          wr_i,
  input  logic             clr_i,
  input  logic             clr_bank_i
);

  logic [ENT_W-1:0]            mem_q [2**(IDX_W+1)];
  logic [1:0][CELLS-1:0]       written_q;
  logic [1:0]                  fill_q;
  logic                        hit_q;
  logic [ENT_W-1:0]            raw_q;
  logic [ENT_W-1:0]            sub_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[{wr_i.bank, wr_i.idx}] <= wr_i.val;
    end
    if (rd_i.en) begin
      raw_q <= mem_q[{rd_i.bank, rd_i.idx}];
      sub_q <= fill_q[rd_i.bank] ? INIT_TAB[rd_i.idx] : EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      fill_q    <= 2'b01;
      hit_q     <= 1'b0;
    end else begin
      if (clr_i) begin
        written_q[clr_bank_i] <= '0;
        fill_q[clr_bank_i]    <= 1'b0;
      end
      if (wr_i.en) begin
        written_q[wr_i.bank][wr_i.idx] <= 1'b1;
      end
      if (rd_i.en) begin
        hit_q <= written_q[rd_i.bank][rd_i.idx];
      end
    end
  end

  assign rd_data_o = hit_q ? raw_q : sub_q;

endmodule

// ----- hdl/swsm_scan.sv -----
// ----------------------------------------------------------------------------
// swsm_scan
// Accumulates one sweep of the table: slots in use, the furthest occupied
// entry from the target and the target's own entry.
// ----------------------------------------------------------------------------
module swsm_scan import swsm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             take_i,
  input  logic [POS_W-1:0] pos_x_i,
  input  logic [POS_W-1:0] pos_y_i,
  input  logic [ENT_W-1:0] val_i,
  input  logic [POS_W-1:0] tgt_x_i,
  input  logic [POS_W-1:0] tgt_y_i,
  output scan_res_t        res_o
);

  logic [WINDOW-1:0] used_q;
  logic              found_q;
  logic [DIST_W-1:0] best_d_q;
  logic [POS_W-1:0]  far_x_q;
  logic [POS_W-1:0]  far_y_q;
  logic [ENT_W-1:0]  far_slot_q;
  logic [ENT_W-1:0]  tgt_q;
  logic [POS_W-1:0]  dx;
  logic [POS_W-1:0]  dy;
  logic [DIST_W-1:0] dist_sum;

  assign dx       = (pos_x_i > tgt_x_i) ? pos_x_i - tgt_x_i : tgt_x_i - pos_x_i;
  assign dy       = (pos_y_i > tgt_y_i) ? pos_y_i - tgt_y_i : tgt_y_i - pos_y_i;
  assign dist_sum = DIST_W'(dx) + DIST_W'(dy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      found_q  <= 1'b0;
      best_d_q <= '0;
    end else if (clear_i) begin
      used_q   <= '0;
      found_q  <= 1'b0;
      best_d_q <= '0;
    end else if (take_i) begin
      if (val_i < EMPTY) begin
        used_q[POS_W'(val_i)] <= 1'b1;
        if (dist_sum > best_d_q) begin
          found_q  <= 1'b1;
          best_d_q <= dist_sum;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      if (pos_x_i == tgt_x_i && pos_y_i == tgt_y_i) begin
        tgt_q <= val_i;
      end
      if (val_i < EMPTY && dist_sum > best_d_q) begin
        far_x_q    <= pos_x_i;
        far_y_q    <= pos_y_i;
        far_slot_q <= val_i;
      end
    end
  end

  always_comb begin
    res_o           = '0;
    res_o.far_ok    = found_q;
    res_o.far_x     = far_x_q;
    res_o.far_y     = far_y_q;
    res_o.far_slot  = far_slot_q;
    res_o.tgt_slot  = tgt_q;
    res_o.free_slot = EMPTY;
    for (int k = WINDOW - 1; k >= 0; k--) begin
      if (!used_q[k]) begin
        res_o.free_ok   = 1'b1;
        res_o.free_slot = ENT_W'(k);
      end
    end
  end

endmodule

// ----- hdl/swsm_checker.sv -----
// ----------------------------------------------------------------------------
// swsm_checker
// Port-level checks of the sliding window slot map, bound to the top level.
// ----------------------------------------------------------------------------
module swsm_checker import swsm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               kind_i,
  input logic [COORD_W-1:0] block_x_i,
  input logic [COORD_W-1:0] block_y_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [SLOT_W-1:0]  slot_o,
  input logic               loaded_o,
  input logic [COORD_W-1:0] origin_x_o,
  input logic [COORD_W-1:0] origin_y_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slot_o) &&
      $stable(loaded_o) && $stable(origin_x_o) && $stable(origin_y_o))
    else $error("result item changed while stalled");

  a_loaded_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && loaded_o |-> slot_o < SLOT_W'(WINDOW))
    else $error("loaded item reports a slot out of range");

  a_empty_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !loaded_o |-> slot_o == SLOT_W'(WINDOW))
    else $error("unloaded item reports a real slot");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in work");

endmodule

bind sliding_window_slot_map swsm_checker u_swsm_checker (.*);
